>>> hdl/pedal_plausibility_fault_monitor_assert.svh
// assertion macros for the pedal plausibility fault monitor
`ifndef PEDAL_PLAUSIBILITY_FAULT_MONITOR_ASSERT_SVH
`define PEDAL_PLAUSIBILITY_FAULT_MONITOR_ASSERT_SVH

// same-cycle implication, quiet while reset is held
`define PPFM_ASSERT_IMPLY(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("ppfm assertion failed");

// next-cycle implication, quiet while reset is held
`define PPFM_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("ppfm assertion failed");

// next-cycle implication that also holds across reset
`define PPFM_ASSERT_NEXT_ANY(name, clk, pre, post) \
  name: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("ppfm assertion failed");

`endif

>>> hdl/ppfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppfm_pkg;

  localparam int unsigned DEBOUNCE_COUNT_DEF = 100;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes
  localparam logic [1:0] REG_THROTTLE_OFFSET     = 2'd0;
  localparam logic [1:0] REG_THROTTLE_DIFF_LIMIT = 2'd1;
  localparam logic [1:0] REG_BRAKE_DIFF_LIMIT    = 2'd2;
  localparam logic [1:0] REG_RESET_GRACE_MS      = 2'd3;

  localparam logic [11:0] THROTTLE_OFFSET_RST     = 12'd0;
  localparam logic [11:0] THROTTLE_DIFF_LIMIT_RST = 12'd410;
  localparam logic [11:0] BRAKE_DIFF_LIMIT_RST    = 12'd410;
  localparam logic [31:0] RESET_GRACE_MS_RST      = 32'd1000;

  // command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_MSG  = 1'b1;

  // decoded bus message kinds
  localparam logic [1:0] MSG_RESET        = 2'd0;
  localparam logic [1:0] MSG_REMOTE_FATAL = 2'd1;
  localparam logic [1:0] MSG_CLEAR_ACK    = 2'd2;
  localparam logic [1:0] MSG_OTHER        = 2'd3;

  // fatal message codes
  localparam logic [1:0] FMSG_NONE    = 2'd0;
  localparam logic [1:0] FMSG_FATAL   = 2'd1;
  localparam logic [1:0] FMSG_CONSENT = 2'd2;

  // x * 2.2 = floor(x * 11 * 52429 / 2^18), exact for x * 11 below 2^18
  localparam logic [19:0] SCALE_MUL   = 20'd576719;
  localparam int unsigned SCALE_SHIFT = 18;

  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 56;

  typedef struct packed {
    logic [11:0] throttle_offset;
    logic [11:0] throttle_diff_limit;
    logic [11:0] brake_diff_limit;
    logic [31:0] reset_grace_ms;
  } cfg_t;

  // last field (throttle_a) in the lowest bits
  typedef struct packed {
    logic [1:0]  message_kind;
    logic [31:0] now_ms;
    logic        nr_pin_low;
    logic        bspd_pin_low;
    logic [11:0] current_raw;
    logic [11:0] brake_b;
    logic [11:0] brake_a;
    logic [11:0] throttle_b;
    logic [11:0] throttle_a;
  } in_data_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic        clear_request;
    logic [1:0]  fatal_message;
    logic        fatal_fault;
    logic        recoverable_fault;
    logic        bppc_fault;
    logic        bspd_fault;
    logic [3:0]  pedal_status;
    logic [11:0] current;
    logic [11:0] brake;
    logic [13:0] throttle;
  } out_data_t;

  typedef struct packed {
    logic [13:0] throttle;
    logic [11:0] brake;
    logic        t_mm;
    logic        b_mm;
    logic        t_pr;
    logic        b_pr;
  } pedal_t;

  typedef struct packed {
    logic       bspd;
    logic       bppc;
    logic       rec;
    logic       fatal;
    logic [1:0] fmsg;
    logic       clear_req;
  } fault_t;

  typedef struct packed {
    logic tick;
    logic msg;
  } step_t;

endpackage

`default_nettype wire

>>> hdl/pedal_plausibility_fault_monitor.sv
// pedal plausibility and fault monitor
// in_* stream: one transaction per sample tick (in_tuser = 0) or decoded bus
//   message (in_tuser = 1). a tick gives exactly one out_* transaction, a
//   message only updates the fault state and gives none.
// cfg_* port: apb-style writes to the offset, mismatch limits and reset grace
//   time; pready is tied high. write only while the stream is idle.
// a tick's result reaches out_tvalid through the input register, then the
//   result register.
// throughput: one transaction per cycle while the result is not stalled; the
//   input register and the result register form a two-entry pipe, and the
//   fault state is updated as an item moves out of the input register.
// when out_tready is low the result holds, the item behind it waits in the
//   input register and in_tready drops once both are full; messages still
//   drain past a stalled result.
// reset (rst_n low, synchronous) empties both registers, clears all latched
//   faults and the debounce count and reloads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module pedal_plausibility_fault_monitor #(
  parameter int unsigned DEBOUNCE_COUNT = ppfm_pkg::DEBOUNCE_COUNT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // throttle_a, throttle_b, brake_a, brake_b, current_raw, bspd_pin_low,
  // nr_pin_low, now_ms, message_kind
  input  wire logic [ppfm_pkg::IN_DATA_W-1:0]     in_tdata,
  // command
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // throttle, brake, current, pedal_status, bspd_fault, bppc_fault,
  // recoverable_fault, fatal_fault, fatal_message, clear_request, zero pad
  output logic      [ppfm_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [ppfm_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [ppfm_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic      [ppfm_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                    cfg_pready
);
  import ppfm_pkg::*;

  cfg_t      cfg;
  pedal_t    ped;
  fault_t    flt;
  step_t     ctl;

  logic      s1_valid_r, s1_valid_nxt;
  logic      s1_cmd_r;
  in_data_t  s1_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_data_t out_data_r;
  out_data_t res;

  logic      in_acc;
  logic      adv;
  logic      out_free;

  assign out_free = !out_valid_r || out_tready;
  assign adv      = s1_valid_r && ((s1_cmd_r == CMD_MSG) || out_free);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  assign ctl.tick = adv && (s1_cmd_r == CMD_TICK);
  assign ctl.msg  = adv && (s1_cmd_r == CMD_MSG);

  ppfm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  ppfm_pedal u_pedal (
    .item (s1_data_r),
    .cfg  (cfg),
    .ped  (ped)
  );

  ppfm_fault #(
    .DEBOUNCE_COUNT (DEBOUNCE_COUNT)
  ) u_fault (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .item  (s1_data_r),
    .ped   (ped),
    .cfg   (cfg),
    .flt   (flt)
  );

  always_comb begin
    res.pad               = '0;
    res.clear_request     = flt.clear_req;
    res.fatal_message     = flt.fmsg;
    res.fatal_fault       = flt.fatal;
    res.recoverable_fault = flt.rec;
    res.bppc_fault        = flt.bppc;
    res.bspd_fault        = flt.bspd;
    res.pedal_status      = {ped.t_mm, ped.b_mm, ped.t_pr, ped.b_pr};
    res.current           = s1_data_r.current_raw;
    res.brake             = ped.brake;
    res.throttle          = ped.throttle;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (ctl.tick) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data_t'(in_tdata);
      s1_cmd_r  <= in_tuser;
    end
    if (ctl.tick) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> hdl/ppfm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module ppfm_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ppfm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [ppfm_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [ppfm_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                   pready,
  output ppfm_pkg::cfg_t                         cfg
);
  import ppfm_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_THROTTLE_OFFSET:     cfg_nxt.throttle_offset     = pwdata[11:0];
        REG_THROTTLE_DIFF_LIMIT: cfg_nxt.throttle_diff_limit = pwdata[11:0];
        REG_BRAKE_DIFF_LIMIT:    cfg_nxt.brake_diff_limit    = pwdata[11:0];
        REG_RESET_GRACE_MS:      cfg_nxt.reset_grace_ms      = pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THROTTLE_OFFSET:     prdata = {20'd0, cfg_r.throttle_offset};
      REG_THROTTLE_DIFF_LIMIT: prdata = {20'd0, cfg_r.throttle_diff_limit};
      REG_BRAKE_DIFF_LIMIT:    prdata = {20'd0, cfg_r.brake_diff_limit};
      REG_RESET_GRACE_MS:      prdata = cfg_r.reset_grace_ms;
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.throttle_offset     <= THROTTLE_OFFSET_RST;
      cfg_r.throttle_diff_limit <= THROTTLE_DIFF_LIMIT_RST;
      cfg_r.brake_diff_limit    <= BRAKE_DIFF_LIMIT_RST;
      cfg_r.reset_grace_ms      <= RESET_GRACE_MS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> hdl/ppfm_pedal.sv
`timescale 1ns / 1ps
`default_nettype none

module ppfm_pedal (
  input  ppfm_pkg::in_data_t item,
  input  ppfm_pkg::cfg_t     cfg,
  output ppfm_pkg::pedal_t   ped
);
  import ppfm_pkg::*;

  logic [12:0] t_sum;
  logic [12:0] b_sum;
  logic [11:0] t_avg;
  logic [11:0] t_net;
  logic [31:0] t_prod;
  logic [11:0] t_diff;
  logic [11:0] b_diff;

  always_comb begin
    t_sum = {1'b0, item.throttle_a} + {1'b0, item.throttle_b};
    b_sum = {1'b0, item.brake_a} + {1'b0, item.brake_b};
    t_avg = t_sum[12:1];
    // clamp at zero when the dead band covers the average
    t_net = (t_avg > cfg.throttle_offset) ? (t_avg - cfg.throttle_offset) : 12'd0;
    t_prod = {20'd0, t_net} * {12'd0, SCALE_MUL};

    t_diff = (item.throttle_a > item.throttle_b) ? (item.throttle_a - item.throttle_b)
                                                 : (item.throttle_b - item.throttle_a);
    b_diff = (item.brake_a > item.brake_b) ? (item.brake_a - item.brake_b)
                                           : (item.brake_b - item.brake_a);

    ped.throttle = t_prod[SCALE_SHIFT +: 14];
    ped.brake    = b_sum[12:1];
    ped.t_mm     = t_diff > cfg.throttle_diff_limit;
    ped.b_mm     = b_diff > cfg.brake_diff_limit;
    ped.t_pr     = t_net != 12'd0;
    ped.b_pr     = b_sum[12:1] != 12'd0;
  end

endmodule

`default_nettype wire

>>> hdl/ppfm_fault.sv
`timescale 1ns / 1ps
`default_nettype none

module ppfm_fault #(
  parameter int unsigned DEBOUNCE_COUNT = ppfm_pkg::DEBOUNCE_COUNT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  ppfm_pkg::step_t    ctl,
  input  ppfm_pkg::in_data_t item,
  input  ppfm_pkg::pedal_t   ped,
  input  ppfm_pkg::cfg_t     cfg,
  output ppfm_pkg::fault_t   flt
);
  import ppfm_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEBOUNCE_COUNT + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEBOUNCE_COUNT);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pin_lat_r, pin_lat_nxt;
  logic             bspd_r, bspd_nxt;
  logic             bppc_lat_r, bppc_lat_nxt;
  logic             prev_t_r, prev_t_nxt;
  logic             prev_b_r, prev_b_nxt;
  logic             seen_r, seen_nxt;
  logic             clr_r, clr_nxt;
  logic             win_r, win_nxt;
  logic [31:0]      win_start_r, win_start_nxt;
  logic             remote_r, remote_nxt;

  logic             bppc;
  logic             rec;
  logic             pin_fault;
  logic             fatal;
  logic [31:0]      elapsed;

  always_comb begin
    cnt_nxt       = cnt_r;
    pin_lat_nxt   = pin_lat_r;
    bspd_nxt      = bspd_r;
    bppc_lat_nxt  = bppc_lat_r;
    prev_t_nxt    = prev_t_r;
    prev_b_nxt    = prev_b_r;
    seen_nxt      = seen_r;
    clr_nxt       = clr_r;
    win_nxt       = win_r;
    win_start_nxt = win_start_r;
    remote_nxt    = remote_r;
    pin_fault     = 1'b0;

    bppc    = bppc_lat_r ? prev_t_r : (prev_t_r & prev_b_r);
    rec     = ped.t_mm | ped.b_mm | bppc;
    elapsed = item.now_ms - win_start_r;

    if (ctl.tick) begin
      bspd_nxt     = bspd_r | item.bspd_pin_low;
      bppc_lat_nxt = bppc;
      seen_nxt     = rec;
      // a fault that has gone away asks for a clear notice
      if (seen_r && !rec) begin
        clr_nxt = 1'b1;
      end
      if (!win_r) begin
        if (pin_lat_r) begin
          pin_fault = 1'b1;
        end else if (item.nr_pin_low && (cnt_r < CNT_MAX)) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          cnt_nxt = '0;
          if (item.nr_pin_low) begin
            pin_lat_nxt = 1'b1;
            pin_fault   = 1'b1;
          end
        end
      end else begin
        pin_lat_nxt = 1'b0;
        if (elapsed > cfg.reset_grace_ms) begin
          win_nxt = 1'b0;
        end
      end
      prev_t_nxt = ped.t_pr;
      prev_b_nxt = ped.b_pr;
      remote_nxt = 1'b0;
    end

    if (ctl.msg) begin
      case (item.message_kind)
        MSG_RESET: begin
          if (!win_r) begin
            win_nxt       = 1'b1;
            win_start_nxt = item.now_ms;
          end
        end
        MSG_REMOTE_FATAL: remote_nxt = 1'b1;
        MSG_CLEAR_ACK:    clr_nxt    = 1'b0;
        default: ;
      endcase
    end

    fatal = win_r ? bspd_nxt : (bspd_nxt | pin_fault | remote_r);

    flt.bspd      = bspd_nxt;
    flt.bppc      = bppc;
    flt.rec       = rec;
    flt.fatal     = fatal;
    flt.fmsg      = fatal ? FMSG_FATAL : (win_r ? FMSG_CONSENT : FMSG_NONE);
    flt.clear_req = clr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pin_lat_r   <= 1'b0;
      bspd_r      <= 1'b0;
      bppc_lat_r  <= 1'b0;
      prev_t_r    <= 1'b0;
      prev_b_r    <= 1'b0;
      seen_r      <= 1'b0;
      clr_r       <= 1'b0;
      win_r       <= 1'b0;
      win_start_r <= '0;
      remote_r    <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      pin_lat_r   <= pin_lat_nxt;
      bspd_r      <= bspd_nxt;
      bppc_lat_r  <= bppc_lat_nxt;
      prev_t_r    <= prev_t_nxt;
      prev_b_r    <= prev_b_nxt;
      seen_r      <= seen_nxt;
      clr_r       <= clr_nxt;
      win_r       <= win_nxt;
      win_start_r <= win_start_nxt;
      remote_r    <= remote_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ppfm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "pedal_plausibility_fault_monitor_assert.svh"

module ppfm_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [ppfm_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ppfm_pkg::*;

  out_data_t res;
  logic      rec_want;
  logic      fmsg_known;
  logic      fmsg_ok;
  logic      thr_pr_ok;

  assign res        = out_data_t'(out_tdata);
  assign rec_want   = res.pedal_status[3] | res.pedal_status[2] | res.bppc_fault;
  assign fmsg_known = (res.fatal_message == FMSG_NONE) ||
                      (res.fatal_message == FMSG_FATAL) ||
                      (res.fatal_message == FMSG_CONSENT);
  assign fmsg_ok    = (res.fatal_fault == (res.fatal_message == FMSG_FATAL)) && fmsg_known;
  assign thr_pr_ok  = res.pedal_status[1] == (res.throttle != 14'd0);

  // reset empties the result register
  `PPFM_ASSERT_NEXT_ANY(a_reset_empty, clk, !rst_n, !out_tvalid)

  // a stalled result is not dropped
  `PPFM_ASSERT_NEXT(a_stall_keep, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // recoverable fault is exactly the two mismatches and the overlap fault
  `PPFM_ASSERT_IMPLY(a_rec_sum, clk, rst_n, out_tvalid, res.recoverable_fault == rec_want)

  // fatal line and fatal announce agree, and consent only comes without a fault
  `PPFM_ASSERT_IMPLY(a_fatal_msg, clk, rst_n, out_tvalid, fmsg_ok)

  // throttle pressed flag follows the scaled value
  `PPFM_ASSERT_IMPLY(a_thr_pressed, clk, rst_n, out_tvalid, thr_pr_ok)

endmodule

bind pedal_plausibility_fault_monitor ppfm_checker u_ppfm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
